>>> rtl/sdd_pkg.sv
package sdd_pkg;

   // Input item operations
   localparam logic [1:0] OP_WRITE_MATRIX = 2'd0;
   localparam logic [1:0] OP_WRITE_WEIGHT = 2'd1;
   localparam logic [1:0] OP_COMPUTE      = 2'd2;
   localparam logic [1:0] OP_RESERVED     = 2'd3;

   // Configuration register indexes
   localparam logic CSR_RESULT_MODE = 1'b0;
   localparam logic CSR_ACTIVE_DIM  = 1'b1;

   // Result mode codes
   localparam logic MODE_SCALAR = 1'b0;
   localparam logic MODE_MATRIX = 1'b1;

   // Compute sequencer states
   typedef enum logic [14:0] {
      S_IDLE  = 15'b000000000000001,
      S_PRD   = 15'b000000000000010,
      S_PWT   = 15'b000000000000100,
      S_RA    = 15'b000000000001000,
      S_RB    = 15'b000000000010000,
      S_RC    = 15'b000000000100000,
      S_MUL   = 15'b000000001000000,
      S_DIVS  = 15'b000000010000000,
      S_DIV   = 15'b000000100000000,
      S_SUB   = 15'b000001000000000,
      S_F1    = 15'b000010000000000,
      S_F2    = 15'b000100000000000,
      S_F3    = 15'b001000000000000,
      S_F4    = 15'b010000000000000,
      S_OUT   = 15'b100000000000000
   } state_type;

   // Clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/sdd_store.sv
module sdd_store #(
   parameter int MAX_DIM = 8
) (
   input  logic                                   clock,
   input  logic                                   m_we,
   input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     m_waddr,
   input  logic signed [31:0]                     m_wdata,
   input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]     m_raddr,
   output logic signed [31:0]                     m_rdata,
   input  logic                                   w_we,
   input  logic [$clog2(MAX_DIM)-1:0]             w_waddr,
   input  logic signed [31:0]                     w_wdata,
   input  logic [$clog2(MAX_DIM)-1:0]             w_raddr,
   output logic signed [31:0]                     w_rdata
);

   logic signed [31:0] matrix_mem [MAX_DIM*MAX_DIM];
   logic signed [31:0] weight_mem [MAX_DIM];

   // Matrix entries: one write, one registered read
   always_ff @(posedge clock) begin
      if (m_we) begin
         matrix_mem[m_waddr] <= m_wdata;
      end
      m_rdata <= matrix_mem[m_raddr];
   end

   // Weight entries: one write, one registered read
   always_ff @(posedge clock) begin
      if (w_we) begin
         weight_mem[w_waddr] <= w_wdata;
      end
      w_rdata <= weight_mem[w_raddr];
   end

endmodule

>>> rtl/sdd_div.sv
module sdd_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [63:0]  num,
   input  logic signed [31:0]  den,
   output logic                done,
   output logic signed [63:0]  quot
);

   logic [63:0]  quo_ff, quo_in;
   logic [32:0]  rem_ff, rem_in;
   logic [31:0]  dmag_ff, dmag_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic         run_ff, run_in;
   logic         neg_ff, neg_in;
   logic         done_ff, done_in;
   logic [32:0]  rem_sh;
   logic         ge;

   assign rem_sh = {rem_ff[31:0], quo_ff[63]};
   assign ge     = rem_sh >= {1'b0, dmag_ff};

   // One quotient bit per cycle, restoring on magnitudes
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dmag_in = dmag_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num[63] ? 64'(-num) : 64'(num);
         rem_in  = '0;
         dmag_in = den[31] ? 32'(-den) : 32'(den);
         cnt_in  = '0;
         run_in  = 1'b1;
         neg_in  = num[63] ^ den[31];
      end else if (run_ff) begin
         rem_in = ge ? rem_sh - {1'b0, dmag_ff} : rem_sh;
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

>>> rtl/schur_complement_downdate.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    opcode, row_sel, col_sel, data_value,
//                                             removed_index
// rsp       out        rsp_valid/rsp_ready    out_row, out_col, out_value, pivot_zero,
//                                             last_item
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// A compute item reads the pivot, then for each reduced entry reads operands, multiplies,
// runs the 64-step bit-serial divider and subtracts, in scalar mode also weighting and
// accumulating; (n-1)^2 entries per item, then the single scalar result. A zero pivot
// skips the divider and in matrix mode emits one entry per cycle unless output stalls.
// Reset is synchronous and clears control state; the stores hold garbage until written.
// Requests are held off while a compute item runs; the result register holds under stall.
module schur_complement_downdate #(
   parameter int MAX_DIM = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_opcode,
   input  logic [2:0]          req_row_sel,
   input  logic [2:0]          req_col_sel,
   input  logic signed [31:0]  req_data_value,
   input  logic [2:0]          req_removed_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_out_row,
   output logic [2:0]          rsp_out_col,
   output logic signed [31:0]  rsp_out_value,
   output logic                rsp_pivot_zero,
   output logic                rsp_last_item,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [3:0]          csr_data
);

   localparam int AW  = $clog2(MAX_DIM*MAX_DIM);
   localparam int WAW = $clog2(MAX_DIM);

   sdd_pkg::state_type state_ff, state_in;

   logic               mode_ff, mode_in;
   logic [3:0]         dim_ff, dim_in;
   logic [2:0]         ri_ff, ri_in;
   logic [2:0]         m_ff, m_in;
   logic [2:0]         a_ff, a_in;
   logic [2:0]         b_ff, b_in;
   logic               pz_ff, pz_in;
   logic signed [31:0] d_ff, d_in;
   logic signed [31:0] xa_ff, xa_in;
   logic signed [31:0] xb_ff, xb_in;
   logic signed [31:0] ua_ff, ua_in;
   logic signed [31:0] ub_ff, ub_in;
   logic signed [31:0] aij_ff, aij_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] red_ff, red_in;
   logic signed [31:0] ts_ff, ts_in;
   logic signed [63:0] acc_ff, acc_in;
   logic               rv_ff, rv_in;
   logic [2:0]         rrow_ff, rrow_in;
   logic [2:0]         rcol_ff, rcol_in;
   logic signed [31:0] rval_ff, rval_in;
   logic               rpz_ff, rpz_in;
   logic               rlast_ff, rlast_in;

   logic               req_fire;
   logic [3:0]         n_eff;
   logic [2:0]         ia, ib;
   logic               last_ent;
   logic               out_free;
   logic [AW-1:0]      m_raddr, m_waddr;
   logic [WAW-1:0]     w_raddr;
   logic signed [31:0] m_rdata, w_rdata;
   logic               m_we, w_we;
   logic               div_start, div_done;
   logic signed [63:0] div_q;

   function automatic logic [AW-1:0] maddr(input logic [2:0] r, input logic [2:0] c);
      return AW'(int'(r) * MAX_DIM + int'(c));
   endfunction

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == sdd_pkg::S_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Clamp the active size into range
   always_comb begin
      if (dim_ff < 4'd2) begin
         n_eff = 4'd2;
      end else if (dim_ff > 4'(MAX_DIM)) begin
         n_eff = 4'(MAX_DIM);
      end else begin
         n_eff = dim_ff;
      end
   end

   // Skip the removed index when mapping reduced positions to stored ones
   assign ia       = a_ff + 3'(a_ff >= ri_ff);
   assign ib       = b_ff + 3'(b_ff >= ri_ff);
   assign last_ent = (a_ff == m_ff) && (b_ff == m_ff);
   assign out_free = !rv_ff || rsp_ready;

   // Load writes straight from the input channel
   assign m_we    = req_fire && (req_opcode == sdd_pkg::OP_WRITE_MATRIX)
                    && (int'(req_row_sel) < MAX_DIM) && (int'(req_col_sel) < MAX_DIM);
   assign w_we    = req_fire && (req_opcode == sdd_pkg::OP_WRITE_WEIGHT)
                    && (int'(req_row_sel) < MAX_DIM);
   assign m_waddr = maddr(req_row_sel, req_col_sel);

   // Read addresses by sequencer step
   always_comb begin
      m_raddr = maddr(ia, ib);
      w_raddr = WAW'(ia);
      unique case (state_ff)
         sdd_pkg::S_PRD: m_raddr = maddr(ri_ff, ri_ff);
         sdd_pkg::S_RA:  m_raddr = maddr(ia, ri_ff);
         sdd_pkg::S_RB: begin
            m_raddr = maddr(ib, ri_ff);
            w_raddr = WAW'(ib);
         end
         default: ;
      endcase
   end

   sdd_store #(.MAX_DIM(MAX_DIM)) u_store (
      .clock   (clock),
      .m_we    (m_we),
      .m_waddr (m_waddr),
      .m_wdata (req_data_value),
      .m_raddr (m_raddr),
      .m_rdata (m_rdata),
      .w_we    (w_we),
      .w_waddr (WAW'(req_row_sel)),
      .w_wdata (req_data_value),
      .w_raddr (w_raddr),
      .w_rdata (w_rdata)
   );

   assign div_start = (state_ff == sdd_pkg::S_DIVS);

   sdd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (prod_ff),
      .den   (d_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      dim_in   = dim_ff;
      ri_in    = ri_ff;
      m_in     = m_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      pz_in    = pz_ff;
      d_in     = d_ff;
      xa_in    = xa_ff;
      xb_in    = xb_ff;
      ua_in    = ua_ff;
      ub_in    = ub_ff;
      aij_in   = aij_ff;
      prod_in  = prod_ff;
      red_in   = red_ff;
      ts_in    = ts_ff;
      acc_in   = acc_ff;
      rv_in    = rv_ff && !rsp_ready;
      rrow_in  = rrow_ff;
      rcol_in  = rcol_ff;
      rval_in  = rval_ff;
      rpz_in   = rpz_ff;
      rlast_in = rlast_ff;

      // Take configuration writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sdd_pkg::CSR_RESULT_MODE: mode_in = csr_data[0];
            sdd_pkg::CSR_ACTIVE_DIM:  dim_in  = csr_data;
         endcase
      end

      unique case (state_ff)
         sdd_pkg::S_IDLE: begin
            if (req_fire && (req_opcode == sdd_pkg::OP_COMPUTE)
                && ({1'b0, req_removed_index} < n_eff)) begin
               ri_in    = req_removed_index;
               m_in     = 3'(n_eff - 4'd2);
               a_in     = '0;
               b_in     = '0;
               state_in = sdd_pkg::S_PRD;
            end
         end
         sdd_pkg::S_PRD: state_in = sdd_pkg::S_PWT;
         sdd_pkg::S_PWT: begin
            d_in     = m_rdata;
            pz_in    = (m_rdata == 32'sd0);
            acc_in   = '0;
            state_in = (m_rdata == 32'sd0) ? sdd_pkg::S_OUT : sdd_pkg::S_RA;
         end
         sdd_pkg::S_RA: state_in = sdd_pkg::S_RB;
         sdd_pkg::S_RB: begin
            xa_in    = m_rdata;
            ua_in    = w_rdata;
            state_in = sdd_pkg::S_RC;
         end
         sdd_pkg::S_RC: begin
            xb_in    = m_rdata;
            ub_in    = w_rdata;
            state_in = sdd_pkg::S_MUL;
         end
         sdd_pkg::S_MUL: begin
            aij_in   = m_rdata;
            prod_in  = xa_ff * xb_ff;
            state_in = sdd_pkg::S_DIVS;
         end
         sdd_pkg::S_DIVS: state_in = sdd_pkg::S_DIV;
         sdd_pkg::S_DIV: begin
            if (div_done) begin
               state_in = sdd_pkg::S_SUB;
            end
         end
         sdd_pkg::S_SUB: begin
            red_in   = sdd_pkg::sat32(66'(aij_ff) - 66'(div_q));
            state_in = (mode_ff == sdd_pkg::MODE_MATRIX) ? sdd_pkg::S_OUT : sdd_pkg::S_F1;
         end
         sdd_pkg::S_F1: begin
            prod_in  = ua_ff * red_ff;
            state_in = sdd_pkg::S_F2;
         end
         sdd_pkg::S_F2: begin
            ts_in    = sdd_pkg::sat32(66'(prod_ff >>> 16));
            state_in = sdd_pkg::S_F3;
         end
         sdd_pkg::S_F3: begin
            prod_in  = ts_ff * ub_ff;
            state_in = sdd_pkg::S_F4;
         end
         sdd_pkg::S_F4: begin
            acc_in = acc_ff + (prod_ff >>> 16);
            if (last_ent) begin
               state_in = sdd_pkg::S_OUT;
            end else begin
               if (b_ff == m_ff) begin
                  b_in = '0;
                  a_in = a_ff + 3'd1;
               end else begin
                  b_in = b_ff + 3'd1;
               end
               state_in = sdd_pkg::S_RA;
            end
         end
         sdd_pkg::S_OUT: begin
            // Load the result register once it is free
            if (out_free) begin
               rv_in  = 1'b1;
               rpz_in = pz_ff;
               if (mode_ff == sdd_pkg::MODE_MATRIX) begin
                  rrow_in  = a_ff;
                  rcol_in  = b_ff;
                  rval_in  = pz_ff ? 32'sd0 : red_ff;
                  rlast_in = last_ent;
                  if (last_ent) begin
                     state_in = sdd_pkg::S_IDLE;
                  end else begin
                     if (b_ff == m_ff) begin
                        b_in = '0;
                        a_in = a_ff + 3'd1;
                     end else begin
                        b_in = b_ff + 3'd1;
                     end
                     state_in = pz_ff ? sdd_pkg::S_OUT : sdd_pkg::S_RA;
                  end
               end else begin
                  rrow_in  = '0;
                  rcol_in  = '0;
                  rval_in  = pz_ff ? 32'sd0 : sdd_pkg::sat32(66'(acc_ff));
                  rlast_in = 1'b1;
                  state_in = sdd_pkg::S_IDLE;
               end
            end
         end
         default: state_in = sdd_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdd_pkg::S_IDLE;
         mode_ff  <= sdd_pkg::MODE_SCALAR;
         dim_ff   <= 4'd8;
         rv_ff    <= 1'b0;
         acc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         dim_ff   <= dim_in;
         rv_ff    <= rv_in;
         acc_ff   <= acc_in;
      end
      ri_ff    <= ri_in;
      m_ff     <= m_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      pz_ff    <= pz_in;
      d_ff     <= d_in;
      xa_ff    <= xa_in;
      xb_ff    <= xb_in;
      ua_ff    <= ua_in;
      ub_ff    <= ub_in;
      aij_ff   <= aij_in;
      prod_ff  <= prod_in;
      red_ff   <= red_in;
      ts_ff    <= ts_in;
      rrow_ff  <= rrow_in;
      rcol_ff  <= rcol_in;
      rval_ff  <= rval_in;
      rpz_ff   <= rpz_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_out_row    = rrow_ff;
   assign rsp_out_col    = rcol_ff;
   assign rsp_out_value  = rval_ff;
   assign rsp_pivot_zero = rpz_ff;
   assign rsp_last_item  = rlast_ff;

   // A new result appears only from the output step
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !$past(rv_ff && !rsp_ready)) |-> $past(state_ff == sdd_pkg::S_OUT))
      else $error("result loaded outside output step");

   // A zero pivot always reports a zero value
   a_pz_zero: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rpz_ff) |-> (rval_ff == 32'sd0))
      else $error("zero pivot with nonzero value");

   // Divider completion moves the sequencer on to the subtract step
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sdd_pkg::S_DIV && div_done) |=> (state_ff == sdd_pkg::S_SUB))
      else $error("divider result dropped");

   // The request input is held off while a compute item runs
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != sdd_pkg::S_IDLE) |-> !req_ready)
      else $error("input taken while busy");

endmodule
